// ----- rtl/lacs_pkg.sv -----
// ----------------------------------------------------------------------------
// Lamp array colour store package
// Shared payload types, request codes, default sizes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lacs_pkg;

  // Default geometry: pixels per lamp and the largest number of lamps.
  localparam int GroupSizeDef = 3;
  localparam int MaxGroupsDef = 128;

  // Lamp counts never exceed 256, so nine bits hold every group comparison.
  localparam int GrpCmpW = 9;

  // Reset value of the groups-in-use register.
  localparam logic [7:0] GroupsReset = 8'd73;

  // Request codes.
  localparam logic [2:0] KIND_SET_CURSOR = 3'd0;
  localparam logic [2:0] KIND_CONTROL    = 3'd1;
  localparam logic [2:0] KIND_LAMP       = 3'd2;
  localparam logic [2:0] KIND_RANGE      = 3'd3;
  localparam logic [2:0] KIND_READ_ATTR  = 3'd4;
  localparam logic [2:0] KIND_READ_PIXEL = 3'd5;
  localparam logic [2:0] KIND_LOAD_POS   = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  lamp_group;
    logic [7:0]  range_last;
    logic [8:0]  pixel_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  gain_in;
    logic        autonomous_in;
    logic [21:0] pos_x_in;
    logic [21:0] pos_y_in;
    logic [21:0] pos_z_in;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  reported_lamp;
    logic [21:0] pos_x_out;
    logic [21:0] pos_y_out;
    logic [21:0] pos_z_out;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  gain_out;
    logic        autonomous_out;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // an input beat is taken this cycle
    logic step;      // write one pixel of the current fill and advance
    logic load_out;  // load the output register with the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic starts_fill;  // the offered request needs a pixel fill or clear
    logic fill_last;    // the fill address has reached its end
    logic out_free;     // the output register can take a result
  } sts_t;

endpackage

// ----- rtl/lacs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Lamp array colour store controller
// Sequences the reset clear, request acceptance, pixel fills and result
// hand-off through command signals to the datapath.
// ----------------------------------------------------------------------------
module lacs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lacs_pkg::sts_t sts_i,
  output lacs_pkg::cmd_t cmd_o
);
  import lacs_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_FILL   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = accept;
    cmd_o.step      = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.starts_fill ? ST_FILL : ST_RESULT;
        end
      end
      ST_FILL: begin
        cmd_o.step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Reset enters the clearing sweep of the pixel store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/lacs_datapath.sv -----
// ----------------------------------------------------------------------------
// Lamp array colour store datapath
// Holds the pixel and position memories, the cursor, the autonomous flag,
// the fill address counter and the output register.
// ----------------------------------------------------------------------------
module lacs_datapath #(
  parameter int GROUP_SIZE = lacs_pkg::GroupSizeDef,
  parameter int MAX_GROUPS = lacs_pkg::MaxGroupsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  lacs_pkg::in_item_t  in_data_i,
  output lacs_pkg::out_item_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lacs_pkg::cmd_t      cmd_i,
  output lacs_pkg::sts_t      sts_o
);
  import lacs_pkg::*;

  localparam int PIXELS = MAX_GROUPS * GROUP_SIZE;
  localparam int PIX_W  = $clog2(PIXELS);
  localparam int LAMP_W = $clog2(MAX_GROUPS);
  localparam int POS_W  = 66;

  logic [31:0]      pix_mem [PIXELS];
  logic [POS_W-1:0] pos_mem [MAX_GROUPS];

  logic [7:0]         groups_q;
  logic [LAMP_W-1:0]  cursor_q;
  logic               flag_q;
  logic [PIX_W-1:0]   fill_addr_q;
  logic [PIX_W-1:0]   fill_end_q;
  logic [31:0]        fill_word_q;
  logic [2:0]         kind_q;
  logic [LAMP_W-1:0]  rep_lamp_q;
  logic               pix_ok_q;
  logic [31:0]        pix_rdata_q;
  logic [POS_W-1:0]   pos_rdata_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic [GrpCmpW-1:0] n_lamps;
  logic [GrpCmpW-1:0] grp9;
  logic [GrpCmpW-1:0] last9;
  logic [GrpCmpW-1:0] end9;
  logic [GrpCmpW-1:0] cur_inc;
  logic [GrpCmpW-1:0] fill_lo9;
  logic [GrpCmpW-1:0] fill_hi9;
  logic               grp_ok;
  logic               range_ok;
  logic               pix_ok;
  logic               clear_req;
  logic               starts_fill;
  logic [PIX_W-1:0]   start_pix;
  logic [PIX_W-1:0]   end_pix;
  out_item_t          result;

  // Effective lamp count: zero acts as one, large values saturate.
  always_comb begin
    if (groups_q == 8'd0) begin
      n_lamps = GrpCmpW'(1);
    end else if ({1'b0, groups_q} > GrpCmpW'(MAX_GROUPS)) begin
      n_lamps = GrpCmpW'(MAX_GROUPS);
    end else begin
      n_lamps = {1'b0, groups_q};
    end
  end

  assign grp9     = {1'b0, in_data_i.lamp_group};
  assign last9    = {1'b0, in_data_i.range_last};
  assign end9     = (last9 > n_lamps - GrpCmpW'(1)) ? n_lamps - GrpCmpW'(1) : last9;
  assign grp_ok   = grp9 < n_lamps;
  assign range_ok = grp9 <= end9;
  assign pix_ok   = 32'(in_data_i.pixel_index) < PIXELS;
  assign clear_req = in_data_i.autonomous_in;
  assign cur_inc  = GrpCmpW'(cursor_q) + GrpCmpW'(1);

  // A single lamp update is a range of one lamp.
  assign fill_lo9 = grp9;
  assign fill_hi9 = (in_data_i.kind == KIND_RANGE) ? end9 : grp9;
  assign start_pix = PIX_W'(32'(LAMP_W'(fill_lo9)) * GROUP_SIZE);
  assign end_pix   = PIX_W'(32'(LAMP_W'(fill_hi9)) * GROUP_SIZE + GROUP_SIZE - 1);

  always_comb begin
    case (in_data_i.kind)
      KIND_CONTROL: starts_fill = clear_req;
      KIND_LAMP:    starts_fill = grp_ok;
      KIND_RANGE:   starts_fill = range_ok;
      default:      starts_fill = 1'b0;
    endcase
  end

  assign sts_o = '{starts_fill: starts_fill,
                   fill_last:   (fill_addr_q == fill_end_q),
                   out_free:    (!out_valid_q || out_ready_i)};

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q    <= GroupsReset;
      cursor_q    <= '0;
      flag_q      <= 1'b1;
      fill_addr_q <= '0;
      fill_end_q  <= PIX_W'(PIXELS - 1);
      fill_word_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        groups_q <= cfg_wdata_i;
      end
      if (cmd_i.step) begin
        fill_addr_q <= fill_addr_q + PIX_W'(1);
      end
      if (cmd_i.accept) begin
        case (in_data_i.kind)
          KIND_SET_CURSOR: begin
            if (grp_ok) begin
              cursor_q <= LAMP_W'(grp9);
            end
          end
          KIND_CONTROL: begin
            flag_q <= in_data_i.autonomous_in;
            if (clear_req) begin
              fill_addr_q <= '0;
              fill_end_q  <= PIX_W'(PIXELS - 1);
              fill_word_q <= '0;
            end
          end
          KIND_LAMP, KIND_RANGE: begin
            fill_addr_q <= start_pix;
            fill_end_q  <= end_pix;
            fill_word_q <= {in_data_i.gain_in, in_data_i.blue_in,
                            in_data_i.green_in, in_data_i.red_in};
          end
          KIND_READ_ATTR: begin
            cursor_q <= (cur_inc >= n_lamps) ? '0 : LAMP_W'(cur_inc);
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request context kept for the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q     <= in_data_i.kind;
      rep_lamp_q <= cursor_q;
      pix_ok_q   <= pix_ok;
    end
  end

  // Pixel memory: one write port for fills, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pix_mem[fill_addr_q] <= fill_word_q;
    end
    if (cmd_i.accept && pix_ok) begin
      pix_rdata_q <= pix_mem[PIX_W'(in_data_i.pixel_index)];
    end
  end

  // Position memory: x in the low bits, then y, then z.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_data_i.kind == KIND_LOAD_POS &&
        grp9 < GrpCmpW'(MAX_GROUPS)) begin
      pos_mem[LAMP_W'(grp9)] <= {in_data_i.pos_z_in, in_data_i.pos_y_in,
                                 in_data_i.pos_x_in};
    end
    if (cmd_i.accept) begin
      pos_rdata_q <= pos_mem[cursor_q];
    end
  end

  always_comb begin
    result                = '0;
    result.autonomous_out = flag_q;
    if (kind_q == KIND_READ_ATTR) begin
      result.reported_lamp = 7'(rep_lamp_q);
      result.pos_x_out     = pos_rdata_q[21:0];
      result.pos_y_out     = pos_rdata_q[43:22];
      result.pos_z_out     = pos_rdata_q[65:44];
    end
    if (kind_q == KIND_READ_PIXEL && pix_ok_q) begin
      result.red_out   = pix_rdata_q[7:0];
      result.green_out = pix_rdata_q[15:8];
      result.blue_out  = pix_rdata_q[23:16];
      result.gain_out  = pix_rdata_q[31:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= result;
    end
  end

  assign out_data_o  = out_data_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/lamp_array_color_store.sv -----
// A result is loaded into the output register, once that is free, after
// its request beat is accepted and, for fills and clears, after the fill.
// A new request is taken only once the previous result has been loaded;
// a full clear writes MAX_GROUPS * GROUP_SIZE pixels (384 at the defaults).
// Reset runs the same clearing sweep over the pixel store before the first
// request beat is taken; the groups register may be written during it.
// ----------------------------------------------------------------------------
// Lamp array colour store
// Pixel colour and gain store for an array of lamps, each lamp a group of
// consecutive pixels, with per-lamp positions and an attribute cursor.
// ----------------------------------------------------------------------------
module lamp_array_color_store #(
  parameter int GROUP_SIZE = lacs_pkg::GroupSizeDef,
  parameter int MAX_GROUPS = lacs_pkg::MaxGroupsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lacs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lacs_pkg::out_item_t out_data_o
);
  import lacs_pkg::*;

  // The controller only sees status flags; every stored data value lives in the
  // datapath, including the output register that parts the two channels.
  cmd_t cmd;
  sts_t sts;

  lacs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath performs cursor, flag and position updates on the accept
  // beat, then walks the fill address counter one pixel a cycle for lamp,
  // range and clear requests.
  lacs_datapath #(
    .GROUP_SIZE (GROUP_SIZE),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- tb/tb_lamp_array_color_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lamp array colour store regression
// Self-checking bench. A driver offers request beats from a queue and a
// monitor takes result beats. Every accepted request is run through an
// in-bench model of the colour, position and cursor state, and the result it
// predicts is compared field by field with the next result beat.
// ----------------------------------------------------------------------------
module tb_lamp_array_color_store;
  import lacs_pkg::*;

  localparam int GroupSize  = GroupSizeDef;
  localparam int MaxGroups  = MaxGroupsDef;
  localparam int PixelCount = GroupSize * MaxGroups;

  // The one request code that the package leaves without a name.
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam int PhaseCount     = 8;
  localparam int PhaseItems     = 190;
  // Beat count after which the sender stops until every result is back.
  localparam int PauseAtBeat    = 700;
  // Result count at which the receiver refuses results for a long stretch.
  localparam int LongHoldAt     = 300;
  localparam int LongHoldCycles = 500;
  // A full clear is the slowest single request; wait well past it at the end.
  localparam int DrainCycles    = 2 * PixelCount;
  localparam int CycleLimit     = 4_000_000;
  localparam int MaxPrinted     = 40;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  lamp_array_color_store dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Model state. This is the bench's own copy of everything the block keeps:
  // the pixel words (gain, blue, green, red from the top byte down), the lamp
  // positions, the attribute cursor, the autonomous flag and the groups
  // register. It is advanced once per accepted request beat.
  // --------------------------------------------------------------------------
  logic [31:0] pixel_model   [PixelCount];
  logic [43:0] lamp_xy_model [MaxGroups];
  logic [21:0] lamp_z_model  [MaxGroups];
  int unsigned cursor_model;
  logic        autonomous_model;
  logic [7:0]  groups_model;

  in_item_t  request_queue[$];
  out_item_t expected_results[$];
  int        mismatch_count;
  int        cycle_count;

  // Stimulus planning. The generator tracks which lamp positions have been
  // loaded and where the cursor will stand, so that an attribute read never
  // lands on a position that was never written.
  bit pos_loaded [MaxGroups];
  int plan_cursor;
  int plan_lamps;

  // A register value of zero behaves as one lamp, and anything above the
  // array size behaves as the full array.
  function automatic int lamps_present(logic [7:0] groups);
    int n;
    n = groups;
    if (n == 0) n = 1;
    if (n > MaxGroups) n = MaxGroups;
    return n;
  endfunction

  function automatic void paint_lamp(int lamp, logic [31:0] colour);
    int p;
    for (int j = 0; j < GroupSize; j++) begin
      p = lamp * GroupSize + j;
      if (p < PixelCount) pixel_model[p] = colour;
    end
  endfunction

  // Applies one request to the model and returns the result it should give.
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t   res;
    int          n;
    int          last_lamp;
    logic [31:0] colour;
    res    = '0;
    n      = lamps_present(groups_model);
    colour = {req.gain_in, req.blue_in, req.green_in, req.red_in};
    case (req.kind)
      KIND_SET_CURSOR: begin
        // A cursor value beyond the strip is dropped.
        if (req.lamp_group < n) cursor_model = req.lamp_group;
      end
      KIND_CONTROL: begin
        autonomous_model = req.autonomous_in;
        if (req.autonomous_in) begin
          foreach (pixel_model[p]) pixel_model[p] = '0;
        end
      end
      KIND_LAMP: begin
        if (req.lamp_group < n) paint_lamp(req.lamp_group, colour);
      end
      KIND_RANGE: begin
        // The end is clamped to the last lamp; start equal to end paints one
        // lamp and a start past the end paints nothing.
        last_lamp = (req.range_last > n - 1) ? n - 1 : req.range_last;
        for (int g = req.lamp_group; g <= last_lamp; g++) paint_lamp(g, colour);
      end
      KIND_READ_ATTR: begin
        res.reported_lamp = 7'(cursor_model);
        res.pos_x_out     = lamp_xy_model[cursor_model][21:0];
        res.pos_y_out     = lamp_xy_model[cursor_model][43:22];
        res.pos_z_out     = lamp_z_model[cursor_model];
        // Wraps to zero also when the strip was shortened under the cursor.
        cursor_model = (cursor_model + 1 >= n) ? 0 : cursor_model + 1;
      end
      KIND_READ_PIXEL: begin
        if (req.pixel_index < PixelCount) begin
          {res.gain_out, res.blue_out, res.green_out, res.red_out} =
            pixel_model[req.pixel_index];
        end
      end
      KIND_LOAD_POS: begin
        // Lamps past the strip may be loaded; ids past the array may not.
        if (req.lamp_group < MaxGroups) begin
          lamp_xy_model[req.lamp_group] = {req.pos_y_in, req.pos_x_in};
          lamp_z_model[req.lamp_group]  = req.pos_z_in;
        end
      end
      default: ;
    endcase
    res.autonomous_out = autonomous_model;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request generation.
  // --------------------------------------------------------------------------
  function automatic in_item_t random_fields();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t request(logic [2:0] kind, logic [7:0] lamp,
                                       logic [7:0] last, logic [8:0] pixel);
    in_item_t r;
    r             = random_fields();
    r.kind        = kind;
    r.lamp_group  = lamp;
    r.range_last  = last;
    r.pixel_index = pixel;
    return r;
  endfunction

  // Mostly well-aimed requests: lamp ids on the strip, short ranges and pixel
  // reads over painted lamps, with a share of ids and indexes from the full
  // field range so that the ignore and clamp paths are exercised too.
  function automatic in_item_t random_request(int n);
    in_item_t r;
    int       pick;
    r    = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 8)       r.kind = KIND_SET_CURSOR;
    else if (pick < 12) r.kind = KIND_CONTROL;
    else if (pick < 37) r.kind = KIND_LAMP;
    else if (pick < 49) r.kind = KIND_RANGE;
    else if (pick < 61) r.kind = KIND_READ_ATTR;
    else if (pick < 86) r.kind = KIND_READ_PIXEL;
    else if (pick < 98) r.kind = KIND_LOAD_POS;
    else                r.kind = KIND_UNUSED;
    if ($urandom_range(0, 9) < 8) r.lamp_group = 8'($urandom_range(0, n - 1));
    case ($urandom_range(0, 9))
      0:       r.range_last = r.lamp_group;
      1, 2:    ;
      default: r.range_last = r.lamp_group + 8'($urandom_range(0, 4));
    endcase
    if ($urandom_range(0, 9) < 8) begin
      r.pixel_index = 9'($urandom_range(0, n * GroupSize - 1));
    end
    // Entering autonomous mode wipes the store, so keep it a rare event.
    if (r.kind == KIND_CONTROL) r.autonomous_in = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  task automatic queue_request(in_item_t req);
    in_item_t load;
    if (req.kind == KIND_READ_ATTR && !pos_loaded[plan_cursor]) begin
      load            = random_fields();
      load.kind       = KIND_LOAD_POS;
      load.lamp_group = 8'(plan_cursor);
      request_queue.push_back(load);
      pos_loaded[plan_cursor] = 1'b1;
    end
    case (req.kind)
      KIND_SET_CURSOR: if (req.lamp_group < plan_lamps) plan_cursor = req.lamp_group;
      KIND_READ_ATTR:  plan_cursor = (plan_cursor + 1 >= plan_lamps) ? 0 : plan_cursor + 1;
      KIND_LOAD_POS:   if (req.lamp_group < MaxGroups) pos_loaded[req.lamp_group] = 1'b1;
      default: ;
    endcase
    request_queue.push_back(req);
  endtask

  // Idle means nothing queued, nothing offered and no result outstanding.
  // Every request gives a result, so this also means the block is at rest.
  // The check is made on the falling edge, once the rising edge has settled.
  task automatic wait_idle();
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_groups(logic [7:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    groups_model = value;
    plan_lamps   = lamps_present(value);
  endtask

  // Gap lengths in cycles: mostly none, often a few, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    check_field("reported_lamp",  got.reported_lamp,  want.reported_lamp);
    check_field("pos_x_out",      got.pos_x_out,      want.pos_x_out);
    check_field("pos_y_out",      got.pos_y_out,      want.pos_y_out);
    check_field("pos_z_out",      got.pos_z_out,      want.pos_z_out);
    check_field("red_out",        got.red_out,        want.red_out);
    check_field("green_out",      got.green_out,      want.green_out);
    check_field("blue_out",       got.blue_out,       want.blue_out);
    check_field("gain_out",       got.gain_out,       want.gain_out);
    check_field("autonomous_out", got.autonomous_out, want.autonomous_out);
  endtask

  // --------------------------------------------------------------------------
  // Request driver. The model is advanced at the very edge that accepts a
  // beat, so its state always matches the order the block sees. After each
  // accepted beat a gap is drawn; now and then a calm stretch with no gaps is
  // run. Once, after PauseAtBeat beats, the driver stops offering until every
  // outstanding result has been collected.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : request_driver
    int gap_left;
    int calm_left;
    int accepted_beats;
    bit pause_done;
    bit slot_free;
    bit paused;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(in_data));
        accepted_beats++;
        gap_left = (calm_left > 0) ? 0 : pick_gap();
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(30, 80);
      end
      if (!pause_done && accepted_beats >= PauseAtBeat && expected_results.size() == 0) begin
        pause_done = 1'b1;
      end
      paused = !pause_done && accepted_beats >= PauseAtBeat;
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0 && !paused) begin
          in_valid <= 1'b1;
          in_data  <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each accepted result beat is checked against the oldest
  // prediction. Ready is lowered for random gaps, and once, at LongHoldAt
  // results, for a long stretch while the driver keeps offering, which lets
  // the block back up and hold off its input.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : result_monitor
    out_item_t want;
    int        gap_left;
    int        calm_left;
    int        hold_left;
    int        results_seen;
    bit        hold_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          compare_result(out_data, want);
        end
        gap_left = (calm_left > 0) ? 0 : pick_gap();
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(30, 80);
        if (!hold_done && results_seen == LongHoldAt) begin
          hold_done = 1'b1;
          hold_left = LongHoldCycles;
        end
      end
      out_ready <= (hold_left == 0 && gap_left == 0);
      if (hold_left > 0) hold_left--;
      else if (gap_left > 0) gap_left--;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("lamp_array_color_store regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence: reset, a directed pass over the special cases at the
  // reset lamp count, a short check of the cursor wrapping after the strip is
  // shortened beneath it, then random phases at a spread of lamp counts that
  // includes zero, one, the array size and the largest register value.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t r;
    foreach (pixel_model[p]) pixel_model[p] = '0;
    foreach (lamp_xy_model[g]) begin
      lamp_xy_model[g] = '0;
      lamp_z_model[g]  = '0;
    end
    cursor_model     = 0;
    autonomous_model = 1'b1;
    groups_model     = GroupsReset;
    plan_cursor      = 0;
    plan_lamps       = lamps_present(GroupsReset);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The store comes out of reset cleared and in autonomous mode.
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd0));
    // Leaving autonomous mode keeps the store.
    r = request(KIND_CONTROL, 8'd0, 8'd0, 9'd0);
    r.autonomous_in = 1'b0;
    queue_request(r);
    // Single lamps at both ends of the strip with extreme colours, then ids
    // just past the strip and at the top of the field, which are dropped.
    r = request(KIND_LAMP, 8'd0, 8'd0, 9'd0);
    {r.red_in, r.green_in, r.blue_in, r.gain_in} = '1;
    queue_request(r);
    r = request(KIND_LAMP, 8'd72, 8'd0, 9'd0);
    {r.red_in, r.green_in, r.blue_in, r.gain_in} = '0;
    queue_request(r);
    queue_request(request(KIND_LAMP, 8'd73, 8'd0, 9'd0));
    queue_request(request(KIND_LAMP, 8'd255, 8'd0, 9'd0));
    // Ranges: start equal to end, start past end, end clamped, start off strip.
    queue_request(request(KIND_RANGE, 8'd10, 8'd10, 9'd0));
    queue_request(request(KIND_RANGE, 8'd20, 8'd15, 9'd0));
    queue_request(request(KIND_RANGE, 8'd60, 8'd255, 9'd0));
    queue_request(request(KIND_RANGE, 8'd73, 8'd80, 9'd0));
    // Reads across the painted lamps, the end of the strip, the end of the
    // store and beyond it.
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd0));
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd32));
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd218));
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd219));
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd383));
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd511));
    // Positions: the last lamp of the array at full scale, an id past the
    // array (dropped) and the last lamp of the strip at zero.
    r = request(KIND_LOAD_POS, 8'd127, 8'd0, 9'd0);
    {r.pos_x_in, r.pos_y_in, r.pos_z_in} = '1;
    queue_request(r);
    queue_request(request(KIND_LOAD_POS, 8'd200, 8'd0, 9'd0));
    r = request(KIND_LOAD_POS, 8'd72, 8'd0, 9'd0);
    {r.pos_x_in, r.pos_y_in, r.pos_z_in} = '0;
    queue_request(r);
    // Cursor on the last lamp wraps after a read; an off-strip set is dropped.
    queue_request(request(KIND_SET_CURSOR, 8'd72, 8'd0, 9'd0));
    queue_request(request(KIND_READ_ATTR, 8'd0, 8'd0, 9'd0));
    queue_request(request(KIND_SET_CURSOR, 8'd200, 8'd0, 9'd0));
    queue_request(request(KIND_READ_ATTR, 8'd0, 8'd0, 9'd0));
    queue_request(request(KIND_UNUSED, 8'd5, 8'd9, 9'd3));
    // Entering autonomous mode clears every pixel.
    r = request(KIND_CONTROL, 8'd0, 8'd0, 9'd0);
    r.autonomous_in = 1'b1;
    queue_request(r);
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd0));

    // Full array: paint and read the very last pixel, park the cursor on the
    // last lamp, then shorten the strip beneath it and read twice.
    write_groups(8'd128);
    queue_request(request(KIND_SET_CURSOR, 8'd127, 8'd0, 9'd0));
    queue_request(request(KIND_LAMP, 8'd127, 8'd0, 9'd0));
    queue_request(request(KIND_READ_PIXEL, 8'd0, 8'd0, 9'd383));
    write_groups(8'd5);
    queue_request(request(KIND_READ_ATTR, 8'd0, 8'd0, 9'd0));
    queue_request(request(KIND_READ_ATTR, 8'd0, 8'd0, 9'd0));

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       write_groups(8'd128);
        1:       write_groups(8'd1);
        2:       write_groups(8'd0);
        3:       write_groups(8'd255);
        6:       write_groups(8'd73);
        default: write_groups(8'($urandom_range(0, 255)));
      endcase
      repeat (PhaseItems) queue_request(random_request(plan_lamps));
    end

    wait_idle();
    // Let the block sit long enough that any stray result would show up.
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("lamp_array_color_store regression: pass");
    end else begin
      $display("lamp_array_color_store regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lacs_pkg.sv
rtl/lacs_ctrl.sv
rtl/lacs_datapath.sv
rtl/lamp_array_color_store.sv
tb/tb_lamp_array_color_store.sv
